// ===== sv/c6502_pkg.sv =====
// ----------------------------------------------------------------------------
// c6502_pkg
// Shared types and codes for the 6502 execute unit.
// ----------------------------------------------------------------------------
package c6502_pkg;

   typedef enum logic [5:0] {
      OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BIT = 6'd3,
      OP_CLC = 6'd4,  OP_CLD = 6'd5,  OP_CLI = 6'd6,  OP_CLV = 6'd7,
      OP_CMP = 6'd8,  OP_CPX = 6'd9,  OP_CPY = 6'd10, OP_DEC = 6'd11,
      OP_DEX = 6'd12, OP_DEY = 6'd13, OP_EOR = 6'd14, OP_INC = 6'd15,
      OP_INX = 6'd16, OP_INY = 6'd17, OP_JMP = 6'd18, OP_LDA = 6'd19,
      OP_LDX = 6'd20, OP_LDY = 6'd21, OP_LSR = 6'd22, OP_NOP = 6'd23,
      OP_ORA = 6'd24, OP_PHA = 6'd25, OP_PHP = 6'd26, OP_PLA = 6'd27,
      OP_PLP = 6'd28, OP_ROL = 6'd29, OP_ROR = 6'd30, OP_SBC = 6'd31,
      OP_SEC = 6'd32, OP_SED = 6'd33, OP_SEI = 6'd34, OP_STA = 6'd35,
      OP_STX = 6'd36, OP_STY = 6'd37, OP_TAX = 6'd38, OP_TAY = 6'd39,
      OP_TSX = 6'd40, OP_TXA = 6'd41, OP_TXS = 6'd42, OP_TYA = 6'd43,
      OP_BCC = 6'd44, OP_BCS = 6'd45, OP_BEQ = 6'd46, OP_BMI = 6'd47,
      OP_BNE = 6'd48, OP_BPL = 6'd49, OP_BVC = 6'd50, OP_BVS = 6'd51
   } op_type;

   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_MEM   = 2'd1,
      WR_STACK = 2'd2
   } wkind_type;

   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0] SP_RESET    = 8'hFF;
   localparam logic [7:0] STATUS_MASK = 8'hDF;

   typedef struct packed {
      logic [5:0]  cmd;
      logic [7:0]  operand;
      logic        on_memory;
      logic [15:0] jump_target;
      logic [1:0]  instr_length;
      logic [2:0]  base_cycles;
   } req_type;

   typedef struct packed {
      logic [7:0]  acc;
      logic [7:0]  x_reg;
      logic [7:0]  y_reg;
      logic [7:0]  stack_ptr;
      logic [7:0]  status;
      logic [15:0] prog_counter;
      logic [31:0] cycle_total;
      logic [1:0]  write_kind;
      logic [7:0]  write_data;
      logic [8:0]  stack_addr;
   } rsp_type;

   // architectural state that feeds back from one instruction to the next
   typedef struct packed {
      logic [7:0]  acc;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  sp;
      logic [7:0]  flags;
      logic [15:0] pc;
      logic [31:0] cycles;
   } arch_type;

endpackage

// ===== sv/c6502_if.sv =====
// ----------------------------------------------------------------------------
// c6502_req_if / c6502_rsp_if
// Valid/ready channels for instructions and results.
// ----------------------------------------------------------------------------
interface c6502_req_if;
   logic               valid;
   logic               ready;
   c6502_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface c6502_rsp_if;
   logic               valid;
   logic               ready;
   c6502_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/c6502_alu.sv =====
// ----------------------------------------------------------------------------
// c6502_alu
// Combinational next-state logic for one decoded instruction.
// ----------------------------------------------------------------------------
module c6502_alu (
   input  c6502_pkg::req_type  req,
   input  c6502_pkg::arch_type cur,
   output c6502_pkg::arch_type nxt,
   output c6502_pkg::rsp_type  rsp
);

   logic [7:0]  m, src, r, sum_b;
   logic [8:0]  sum, cmp_d, cmp_reg;
   logic        cin;
   logic [7:0]  f;
   logic [15:0] base, dest;
   logic [3:0]  cyc;
   logic [1:0]  wk;
   logic [7:0]  wd;
   logic [8:0]  saddr;
   logic        saddr_set;
   logic [2:0]  k;
   logic        flag_sel, want;
   c6502_pkg::arch_type s;

   assign m   = req.operand;
   assign src = req.on_memory ? m : cur.acc;
   assign cin = cur.flags[c6502_pkg::FLAG_C];
   assign sum_b = (req.cmd == c6502_pkg::OP_SBC) ? ~m : m;
   assign sum = {1'b0, cur.acc} + {1'b0, sum_b} + {8'd0, cin};
   assign cmp_reg = (req.cmd == c6502_pkg::OP_CPX) ? {1'b0, cur.x} :
                    (req.cmd == c6502_pkg::OP_CPY) ? {1'b0, cur.y} : {1'b0, cur.acc};
   assign cmp_d = cmp_reg + {1'b0, ~m} + 9'd1;
   assign base = cur.pc + {14'd0, req.instr_length};
   assign dest = base + {{8{m[7]}}, m};
   assign k = 3'(req.cmd - 6'(c6502_pkg::OP_BCC));

   always_comb begin
      unique case (k)
         3'd0, 3'd1: flag_sel = cur.flags[c6502_pkg::FLAG_C];
         3'd2, 3'd4: flag_sel = cur.flags[c6502_pkg::FLAG_Z];
         3'd3, 3'd5: flag_sel = cur.flags[c6502_pkg::FLAG_N];
         default:    flag_sel = cur.flags[c6502_pkg::FLAG_V];
      endcase
      want = (k == 3'd1) || (k == 3'd2) || (k == 3'd3) || (k == 3'd7);
   end

   always_comb begin
      s = cur;
      f = cur.flags;
      r = 8'd0;
      wk = c6502_pkg::WR_NONE;
      wd = 8'd0;
      saddr = 9'd0;
      saddr_set = 1'b0;
      s.pc = base;
      cyc = {1'b0, req.base_cycles};
      case (req.cmd)
         c6502_pkg::OP_ADC, c6502_pkg::OP_SBC: begin
            s.acc = sum[7:0];
            f[c6502_pkg::FLAG_C] = sum[8];
            f[c6502_pkg::FLAG_V] = (cur.acc[7] ^ sum[7]) & (sum_b[7] ^ sum[7]);
            f[c6502_pkg::FLAG_N] = sum[7];
            f[c6502_pkg::FLAG_Z] = (sum[7:0] == 8'd0);
         end
         c6502_pkg::OP_AND, c6502_pkg::OP_EOR, c6502_pkg::OP_ORA,
         c6502_pkg::OP_LDA, c6502_pkg::OP_PLA, c6502_pkg::OP_TXA,
         c6502_pkg::OP_TYA: begin
            case (req.cmd)
               c6502_pkg::OP_AND: r = cur.acc & m;
               c6502_pkg::OP_EOR: r = cur.acc ^ m;
               c6502_pkg::OP_ORA: r = cur.acc | m;
               c6502_pkg::OP_TXA: r = cur.x;
               c6502_pkg::OP_TYA: r = cur.y;
               default:           r = m;
            endcase
            s.acc = r;
            f[c6502_pkg::FLAG_N] = r[7];
            f[c6502_pkg::FLAG_Z] = (r == 8'd0);
            if (req.cmd == c6502_pkg::OP_PLA) begin
               s.sp = cur.sp + 8'd1;
               saddr = {1'b1, s.sp};
               saddr_set = 1'b1;
            end
         end
         c6502_pkg::OP_ASL, c6502_pkg::OP_LSR, c6502_pkg::OP_ROL,
         c6502_pkg::OP_ROR: begin
            case (req.cmd)
               c6502_pkg::OP_ASL: begin
                  f[c6502_pkg::FLAG_C] = src[7]; r = {src[6:0], 1'b0};
               end
               c6502_pkg::OP_LSR: begin
                  f[c6502_pkg::FLAG_C] = src[0]; r = {1'b0, src[7:1]};
               end
               c6502_pkg::OP_ROL: begin
                  f[c6502_pkg::FLAG_C] = src[7]; r = {src[6:0], cin};
               end
               default: begin
                  f[c6502_pkg::FLAG_C] = src[0]; r = {cin, src[7:1]};
               end
            endcase
            f[c6502_pkg::FLAG_N] = r[7];
            f[c6502_pkg::FLAG_Z] = (r == 8'd0);
            if (req.on_memory) begin
               wk = c6502_pkg::WR_MEM; wd = r;
            end else begin
               s.acc = r;
            end
         end
         c6502_pkg::OP_BIT: begin
            f[c6502_pkg::FLAG_N] = m[7];
            f[c6502_pkg::FLAG_V] = m[6];
            f[c6502_pkg::FLAG_Z] = ((cur.acc & m) == 8'd0);
         end
         c6502_pkg::OP_CLC: f[c6502_pkg::FLAG_C] = 1'b0;
         c6502_pkg::OP_CLD: f[c6502_pkg::FLAG_D] = 1'b0;
         c6502_pkg::OP_CLI: f[c6502_pkg::FLAG_I] = 1'b0;
         c6502_pkg::OP_CLV: f[c6502_pkg::FLAG_V] = 1'b0;
         c6502_pkg::OP_SEC: f[c6502_pkg::FLAG_C] = 1'b1;
         c6502_pkg::OP_SED: f[c6502_pkg::FLAG_D] = 1'b1;
         c6502_pkg::OP_SEI: f[c6502_pkg::FLAG_I] = 1'b1;
         c6502_pkg::OP_CMP, c6502_pkg::OP_CPX, c6502_pkg::OP_CPY: begin
            f[c6502_pkg::FLAG_C] = cmp_d[8];
            f[c6502_pkg::FLAG_N] = cmp_d[7];
            f[c6502_pkg::FLAG_Z] = (cmp_d[7:0] == 8'd0);
         end
         c6502_pkg::OP_DEC, c6502_pkg::OP_INC: begin
            r = (req.cmd == c6502_pkg::OP_INC) ? m + 8'd1 : m - 8'd1;
            f[c6502_pkg::FLAG_N] = r[7];
            f[c6502_pkg::FLAG_Z] = (r == 8'd0);
            wk = c6502_pkg::WR_MEM; wd = r;
         end
         c6502_pkg::OP_DEX, c6502_pkg::OP_INX, c6502_pkg::OP_LDX,
         c6502_pkg::OP_TAX, c6502_pkg::OP_TSX: begin
            case (req.cmd)
               c6502_pkg::OP_DEX: r = cur.x - 8'd1;
               c6502_pkg::OP_INX: r = cur.x + 8'd1;
               c6502_pkg::OP_TAX: r = cur.acc;
               c6502_pkg::OP_TSX: r = cur.sp;
               default:           r = m;
            endcase
            s.x = r;
            f[c6502_pkg::FLAG_N] = r[7];
            f[c6502_pkg::FLAG_Z] = (r == 8'd0);
         end
         c6502_pkg::OP_DEY, c6502_pkg::OP_INY, c6502_pkg::OP_LDY,
         c6502_pkg::OP_TAY: begin
            case (req.cmd)
               c6502_pkg::OP_DEY: r = cur.y - 8'd1;
               c6502_pkg::OP_INY: r = cur.y + 8'd1;
               c6502_pkg::OP_TAY: r = cur.acc;
               default:           r = m;
            endcase
            s.y = r;
            f[c6502_pkg::FLAG_N] = r[7];
            f[c6502_pkg::FLAG_Z] = (r == 8'd0);
         end
         c6502_pkg::OP_JMP: s.pc = req.jump_target;
         c6502_pkg::OP_PHA, c6502_pkg::OP_PHP: begin
            if (req.cmd == c6502_pkg::OP_PHP) f[c6502_pkg::FLAG_B] = 1'b1;
            wk = c6502_pkg::WR_STACK;
            wd = (req.cmd == c6502_pkg::OP_PHA) ? cur.acc : (f & c6502_pkg::STATUS_MASK);
            saddr = {1'b1, cur.sp};
            saddr_set = 1'b1;
            s.sp = cur.sp - 8'd1;
         end
         c6502_pkg::OP_PLP: begin
            s.sp = cur.sp + 8'd1;
            saddr = {1'b1, s.sp};
            saddr_set = 1'b1;
            f = m & c6502_pkg::STATUS_MASK;
         end
         c6502_pkg::OP_STA: begin wk = c6502_pkg::WR_MEM; wd = cur.acc; end
         c6502_pkg::OP_STX: begin wk = c6502_pkg::WR_MEM; wd = cur.x; end
         c6502_pkg::OP_STY: begin wk = c6502_pkg::WR_MEM; wd = cur.y; end
         c6502_pkg::OP_TXS: s.sp = cur.x;
         c6502_pkg::OP_BCC, c6502_pkg::OP_BCS, c6502_pkg::OP_BEQ, c6502_pkg::OP_BMI,
         c6502_pkg::OP_BNE, c6502_pkg::OP_BPL, c6502_pkg::OP_BVC, c6502_pkg::OP_BVS: begin
            if (flag_sel == want) begin
               s.pc = dest;
               // extra cycle when the branch lands in another page
               cyc = {1'b0, req.base_cycles} +
                     ((base[15:8] != dest[15:8]) ? 4'd2 : 4'd1);
            end
         end
         default: ;
      endcase
      s.flags = f;
      s.cycles = cur.cycles + {28'd0, cyc};
      if (!saddr_set) saddr = {1'b1, s.sp};
      nxt = s;
      rsp.acc = s.acc;
      rsp.x_reg = s.x;
      rsp.y_reg = s.y;
      rsp.stack_ptr = s.sp;
      rsp.status = f & c6502_pkg::STATUS_MASK;
      rsp.prog_counter = s.pc;
      rsp.cycle_total = s.cycles;
      rsp.write_kind = wk;
      rsp.write_data = wd;
      rsp.stack_addr = saddr;
   end

endmodule

// ===== sv/cpu6502_execute_unit_core.sv =====
// ----------------------------------------------------------------------------
// cpu6502_execute_unit_core
// 6502 execute unit, binary arithmetic, one decoded instruction per transfer.
// ----------------------------------------------------------------------------
// One instruction is taken per cycle unless a stalled result holds the input
// register. A transfer lands in an input register; from there the register
// file, status, PC and cycle count update as the result register is loaded.
// The loop that sets the rate is the architectural state feedback through one
// 8-bit ALU pass. The result register stalls when the result is not taken, and
// the input register stalls with it whenever it holds an instruction.
module cpu6502_execute_unit_core (
   input logic             clock,
   input logic             reset,
   c6502_req_if.sink       req,
   c6502_rsp_if.source     rsp
);

   logic                 in_valid_ff;
   c6502_pkg::req_type   in_ff;
   logic                 out_valid_ff;
   c6502_pkg::rsp_type   out_ff;
   c6502_pkg::arch_type  arch_ff, arch_in;
   c6502_pkg::rsp_type   rsp_in;
   logic                 adv_out, adv_in;

   c6502_alu u_alu (
      .req (in_ff),
      .cur (arch_ff),
      .nxt (arch_in),
      .rsp (rsp_in)
   );

   assign adv_out = !out_valid_ff || rsp.ready;
   assign adv_in  = !in_valid_ff || adv_out;
   assign req.ready   = adv_in;
   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         arch_ff      <= '{acc: 8'd0, x: 8'd0, y: 8'd0, sp: c6502_pkg::SP_RESET,
                           flags: 8'd0, pc: 16'd0, cycles: 32'd0};
      end else begin
         if (adv_in) in_valid_ff <= req.valid;
         if (adv_out) begin
            out_valid_ff <= in_valid_ff;
            if (in_valid_ff) arch_ff <= arch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in && req.valid) in_ff <= req.payload;
      if (adv_out && in_valid_ff) out_ff <= rsp_in;
   end

   // bit 5 of the stored status never becomes set
   assert property (@(posedge clock) disable iff (reset) arch_ff.flags[5] == 1'b0)
      else $error("status bit 5 set");

   // a stalled result keeps the architectural state frozen
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready && in_valid_ff) |=> $stable(arch_ff))
      else $error("state advanced during stall");

   // the reported state is the state just committed
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.prog_counter == arch_ff.pc &&
                        out_ff.cycle_total == arch_ff.cycles))
      else $error("result out of step with state");

endmodule

// ===== tb/tb_cpu6502_execute_unit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpu6502_execute_unit_core
// Sends decoded instructions through the request channel, predicts the
// register file, flags, PC, cycle count and write of each one, and compares
// every result field against the prediction under random bursts and stalls.
// ----------------------------------------------------------------------------
module tb_cpu6502_execute_unit_core;

   logic clock = 1'b0;
   logic reset;
   logic rsp_stall_mode;

   c6502_req_if req_ch();
   c6502_rsp_if rsp_ch();

   cpu6502_execute_unit_core u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   c6502_pkg::arch_type cpu;
   c6502_pkg::rsp_type  expected_q[$];
   int                  error_count = 0;
   int                  burst_left;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void set_nz(input logic [7:0] v);
      cpu.flags[c6502_pkg::FLAG_N] = v[7];
      cpu.flags[c6502_pkg::FLAG_Z] = (v == 8'h00);
   endfunction

   function automatic logic [7:0] add_with_carry(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, b} + {8'h00, cpu.flags[c6502_pkg::FLAG_C]};
      cpu.flags[c6502_pkg::FLAG_C] = sum[8];
      cpu.flags[c6502_pkg::FLAG_V] = (a[7] ^ sum[7]) & (b[7] ^ sum[7]);
      set_nz(sum[7:0]);
      return sum[7:0];
   endfunction

   function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
      logic [8:0] d;
      d = {1'b0, r} + {1'b0, ~m} + 9'd1;
      cpu.flags[c6502_pkg::FLAG_C] = d[8];
      set_nz(d[7:0]);
   endfunction

   // advances the architectural state by one instruction and returns the result
   function automatic c6502_pkg::rsp_type execute_instr(input c6502_pkg::req_type q);
      c6502_pkg::rsp_type o;
      logic [15:0] next_pc, dest;
      logic [31:0] cyc;
      logic [7:0]  src, r;
      logic        cin, cond_set, want;
      int          cond_bit;
      logic [8:0]  saddr;
      logic        saddr_set;
      next_pc = cpu.pc + 16'(q.instr_length);
      cyc = 32'(q.base_cycles);
      src = q.on_memory ? q.operand : cpu.acc;
      cin = cpu.flags[c6502_pkg::FLAG_C];
      o = '0;
      saddr = '0;
      saddr_set = 1'b0;
      case (q.cmd)
         c6502_pkg::OP_ADC: cpu.acc = add_with_carry(cpu.acc, q.operand);
         c6502_pkg::OP_SBC: cpu.acc = add_with_carry(cpu.acc, ~q.operand);
         c6502_pkg::OP_AND: begin cpu.acc &= q.operand; set_nz(cpu.acc); end
         c6502_pkg::OP_ORA: begin cpu.acc |= q.operand; set_nz(cpu.acc); end
         c6502_pkg::OP_EOR: begin cpu.acc ^= q.operand; set_nz(cpu.acc); end
         c6502_pkg::OP_ASL, c6502_pkg::OP_LSR, c6502_pkg::OP_ROL, c6502_pkg::OP_ROR: begin
            if (q.cmd == c6502_pkg::OP_ASL || q.cmd == c6502_pkg::OP_ROL) begin
               cpu.flags[c6502_pkg::FLAG_C] = src[7];
               r = {src[6:0], (q.cmd == c6502_pkg::OP_ROL) ? cin : 1'b0};
            end else begin
               cpu.flags[c6502_pkg::FLAG_C] = src[0];
               r = {(q.cmd == c6502_pkg::OP_ROR) ? cin : 1'b0, src[7:1]};
            end
            set_nz(r);
            if (q.on_memory) begin
               o.write_kind = c6502_pkg::WR_MEM;
               o.write_data = r;
            end else begin
               cpu.acc = r;
            end
         end
         c6502_pkg::OP_BIT: begin
            cpu.flags[c6502_pkg::FLAG_N] = q.operand[7];
            cpu.flags[c6502_pkg::FLAG_V] = q.operand[6];
            cpu.flags[c6502_pkg::FLAG_Z] = ((cpu.acc & q.operand) == 8'h00);
         end
         c6502_pkg::OP_CLC: cpu.flags[c6502_pkg::FLAG_C] = 1'b0;
         c6502_pkg::OP_CLD: cpu.flags[c6502_pkg::FLAG_D] = 1'b0;
         c6502_pkg::OP_CLI: cpu.flags[c6502_pkg::FLAG_I] = 1'b0;
         c6502_pkg::OP_CLV: cpu.flags[c6502_pkg::FLAG_V] = 1'b0;
         c6502_pkg::OP_SEC: cpu.flags[c6502_pkg::FLAG_C] = 1'b1;
         c6502_pkg::OP_SED: cpu.flags[c6502_pkg::FLAG_D] = 1'b1;
         c6502_pkg::OP_SEI: cpu.flags[c6502_pkg::FLAG_I] = 1'b1;
         c6502_pkg::OP_CMP: compare_reg(cpu.acc, q.operand);
         c6502_pkg::OP_CPX: compare_reg(cpu.x, q.operand);
         c6502_pkg::OP_CPY: compare_reg(cpu.y, q.operand);
         c6502_pkg::OP_DEC, c6502_pkg::OP_INC: begin
            r = (q.cmd == c6502_pkg::OP_DEC) ? q.operand - 8'd1 : q.operand + 8'd1;
            set_nz(r);
            o.write_kind = c6502_pkg::WR_MEM;
            o.write_data = r;
         end
         c6502_pkg::OP_DEX: begin cpu.x -= 8'd1; set_nz(cpu.x); end
         c6502_pkg::OP_DEY: begin cpu.y -= 8'd1; set_nz(cpu.y); end
         c6502_pkg::OP_INX: begin cpu.x += 8'd1; set_nz(cpu.x); end
         c6502_pkg::OP_INY: begin cpu.y += 8'd1; set_nz(cpu.y); end
         c6502_pkg::OP_JMP: next_pc = q.jump_target;
         c6502_pkg::OP_LDA: begin cpu.acc = q.operand; set_nz(q.operand); end
         c6502_pkg::OP_LDX: begin cpu.x = q.operand; set_nz(q.operand); end
         c6502_pkg::OP_LDY: begin cpu.y = q.operand; set_nz(q.operand); end
         c6502_pkg::OP_PHA, c6502_pkg::OP_PHP: begin
            if (q.cmd == c6502_pkg::OP_PHP) cpu.flags[c6502_pkg::FLAG_B] = 1'b1;
            o.write_kind = c6502_pkg::WR_STACK;
            o.write_data = (q.cmd == c6502_pkg::OP_PHA) ? cpu.acc
                                                        : (cpu.flags & c6502_pkg::STATUS_MASK);
            saddr = {1'b1, cpu.sp};
            saddr_set = 1'b1;
            cpu.sp -= 8'd1;
         end
         c6502_pkg::OP_PLA, c6502_pkg::OP_PLP: begin
            cpu.sp += 8'd1;
            saddr = {1'b1, cpu.sp};
            saddr_set = 1'b1;
            if (q.cmd == c6502_pkg::OP_PLA) begin
               cpu.acc = q.operand;
               set_nz(q.operand);
            end else begin
               cpu.flags = q.operand & c6502_pkg::STATUS_MASK;
            end
         end
         c6502_pkg::OP_STA: begin o.write_kind = c6502_pkg::WR_MEM; o.write_data = cpu.acc; end
         c6502_pkg::OP_STX: begin o.write_kind = c6502_pkg::WR_MEM; o.write_data = cpu.x; end
         c6502_pkg::OP_STY: begin o.write_kind = c6502_pkg::WR_MEM; o.write_data = cpu.y; end
         c6502_pkg::OP_TAX: begin cpu.x = cpu.acc; set_nz(cpu.x); end
         c6502_pkg::OP_TAY: begin cpu.y = cpu.acc; set_nz(cpu.y); end
         c6502_pkg::OP_TSX: begin cpu.x = cpu.sp; set_nz(cpu.x); end
         c6502_pkg::OP_TXA: begin cpu.acc = cpu.x; set_nz(cpu.acc); end
         c6502_pkg::OP_TXS: cpu.sp = cpu.x;
         c6502_pkg::OP_TYA: begin cpu.acc = cpu.y; set_nz(cpu.acc); end
         c6502_pkg::OP_BCC, c6502_pkg::OP_BCS, c6502_pkg::OP_BEQ, c6502_pkg::OP_BMI,
         c6502_pkg::OP_BNE, c6502_pkg::OP_BPL, c6502_pkg::OP_BVC, c6502_pkg::OP_BVS: begin
            case (q.cmd)
               c6502_pkg::OP_BCC, c6502_pkg::OP_BCS: cond_bit = c6502_pkg::FLAG_C;
               c6502_pkg::OP_BEQ, c6502_pkg::OP_BNE: cond_bit = c6502_pkg::FLAG_Z;
               c6502_pkg::OP_BMI, c6502_pkg::OP_BPL: cond_bit = c6502_pkg::FLAG_N;
               default:                              cond_bit = c6502_pkg::FLAG_V;
            endcase
            want = (q.cmd == c6502_pkg::OP_BCS || q.cmd == c6502_pkg::OP_BEQ ||
                    q.cmd == c6502_pkg::OP_BMI || q.cmd == c6502_pkg::OP_BVS);
            cond_set = cpu.flags[cond_bit];
            if (cond_set == want) begin
               dest = next_pc + {{8{q.operand[7]}}, q.operand};
               cyc += (dest[15:8] != next_pc[15:8]) ? 32'd2 : 32'd1;
               next_pc = dest;
            end
         end
         default: ;
      endcase
      cpu.pc = next_pc;
      cpu.cycles += cyc;
      if (!saddr_set) saddr = {1'b1, cpu.sp};
      o.acc = cpu.acc;
      o.x_reg = cpu.x;
      o.y_reg = cpu.y;
      o.stack_ptr = cpu.sp;
      o.status = cpu.flags & c6502_pkg::STATUS_MASK;
      o.prog_counter = cpu.pc;
      o.cycle_total = cpu.cycles;
      o.stack_addr = saddr;
      return o;
   endfunction

   // sends one instruction with bursty gaps
   task automatic send_instr(input c6502_pkg::req_type q);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.payload <= q;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_q.push_back(execute_instr(q));
   endtask

   function automatic c6502_pkg::req_type rand_instr(input int cmd_lo, input int cmd_hi);
      c6502_pkg::req_type q;
      q.cmd = 6'($urandom_range(cmd_lo, cmd_hi));
      q.operand = 8'($urandom);
      q.on_memory = 1'($urandom);
      q.jump_target = 16'($urandom);
      q.instr_length = 2'($urandom);
      q.base_cycles = 3'($urandom);
      return q;
   endfunction

   function automatic c6502_pkg::req_type make_instr(input c6502_pkg::op_type op,
                                                     input logic [7:0] m,
                                                     input logic mem = 1'b0);
      c6502_pkg::req_type q;
      q.cmd = op;
      q.operand = m;
      q.on_memory = mem;
      q.jump_target = 16'h1234;
      q.instr_length = 2'd2;
      q.base_cycles = 3'd2;
      return q;
   endfunction

   task automatic test_arith_edges();
      c6502_pkg::req_type q;
      send_instr(make_instr(c6502_pkg::OP_LDA, 8'h7F));
      send_instr(make_instr(c6502_pkg::OP_ADC, 8'h01));   // signed overflow into negative
      send_instr(make_instr(c6502_pkg::OP_SEC, 8'h00));
      send_instr(make_instr(c6502_pkg::OP_SBC, 8'hFF));
      send_instr(make_instr(c6502_pkg::OP_ADC, 8'h80));
      send_instr(make_instr(c6502_pkg::OP_ASL, 8'h80, 1'b1));
      send_instr(make_instr(c6502_pkg::OP_ROR, 8'h01, 1'b0));
      send_instr(make_instr(c6502_pkg::OP_TSX, 8'h00));   // negative from sp reset value
      send_instr(make_instr(c6502_pkg::OP_PHP, 8'h00));
      send_instr(make_instr(c6502_pkg::OP_PLP, 8'hFF));
      send_instr(make_instr(c6502_pkg::OP_LDX, 8'h00));
      send_instr(make_instr(c6502_pkg::OP_TXS, 8'h00));
      send_instr(make_instr(c6502_pkg::OP_PLA, 8'h00));   // sp steps up from 00
      send_instr(make_instr(c6502_pkg::OP_PHA, 8'h00));   // sp steps back down to 00
      q = make_instr(c6502_pkg::OP_JMP, 8'h00);
      q.jump_target = 16'hFFFF;
      send_instr(q);
      send_instr(make_instr(c6502_pkg::OP_BNE, 8'h05));   // pc wraps, branch not taken
      send_instr(make_instr(c6502_pkg::OP_BEQ, 8'h80));
      q = make_instr(c6502_pkg::OP_NOP, 8'hFF);
      q.cmd = 6'd63;
      q.instr_length = 2'd0;
      q.base_cycles = 3'd0;
      send_instr(q);
      q.instr_length = 2'd3;
      q.base_cycles = 3'd7;
      send_instr(q);
   endtask

   task automatic test_all_ops();
      for (int c = 0; c <= 63; c++) send_instr(rand_instr(c, c));
   endtask

   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 8)
            send_instr(rand_instr(c6502_pkg::OP_ADC, c6502_pkg::OP_BVS));
         else
            send_instr(rand_instr(0, 63));
      end
   endtask

   task automatic test_branches(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 1))
            send_instr(rand_instr(c6502_pkg::OP_CLC, c6502_pkg::OP_CLV));
         else
            send_instr(rand_instr(c6502_pkg::OP_BCC, c6502_pkg::OP_BVS));
      end
   endtask

   // result checker
   always @(posedge clock) begin
      c6502_pkg::rsp_type e, a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a = rsp_ch.payload;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, a);
            error_count++;
         end else begin
            e = expected_q.pop_front();
            if (a.acc !== e.acc)
               $display("%0t: acc exp %h got %h", $time, e.acc, a.acc);
            if (a.x_reg !== e.x_reg)
               $display("%0t: x_reg exp %h got %h", $time, e.x_reg, a.x_reg);
            if (a.y_reg !== e.y_reg)
               $display("%0t: y_reg exp %h got %h", $time, e.y_reg, a.y_reg);
            if (a.stack_ptr !== e.stack_ptr)
               $display("%0t: stack_ptr exp %h got %h", $time, e.stack_ptr, a.stack_ptr);
            if (a.status !== e.status)
               $display("%0t: status exp %h got %h", $time, e.status, a.status);
            if (a.prog_counter !== e.prog_counter)
               $display("%0t: prog_counter exp %h got %h", $time, e.prog_counter,
                        a.prog_counter);
            if (a.cycle_total !== e.cycle_total)
               $display("%0t: cycle_total exp %h got %h", $time, e.cycle_total,
                        a.cycle_total);
            if (a.write_kind !== e.write_kind)
               $display("%0t: write_kind exp %h got %h", $time, e.write_kind, a.write_kind);
            if (a.write_data !== e.write_data)
               $display("%0t: write_data exp %h got %h", $time, e.write_data, a.write_data);
            if (a.stack_addr !== e.stack_addr)
               $display("%0t: stack_addr exp %h got %h", $time, e.stack_addr, a.stack_addr);
            if (a !== e) error_count++;
         end
      end
   end

   // receiver stalls: alternates between free-running and random stall stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall_mode <= 1'b0;
      end else begin
         if ($urandom_range(0, 63) == 0) rsp_stall_mode <= ~rsp_stall_mode;
         rsp_ch.ready <= rsp_stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
      end
   end

   initial begin
      #5_000_000;
      $display("** cpu6502_execute_unit_core: FAILED **");
      $finish;
   end

   initial begin
      int wait_cycles;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      burst_left = 0;
      cpu = '0;
      cpu.sp = c6502_pkg::SP_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_arith_edges();
      test_all_ops();
      test_branches(300);
      test_random(720);
      req_ch.valid <= 1'b0;
      wait_cycles = 0;
      while (expected_q.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0)
         $display("** cpu6502_execute_unit_core: PASSED **");
      else
         $display("** cpu6502_execute_unit_core: FAILED **");
      $finish;
   end

endmodule
